// ===== rtl/bdown_pkg.sv =====
// ============================================================================
// bdown_pkg
// Shared types, widths and constant tables for the block average downscaler.
// ============================================================================
`default_nettype none

package bdown_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 16;
  localparam int FACTOR_W   = 5;
  localparam int DIM_W      = 11;
  localparam int MAX_FACTOR = 16;
  localparam int BLK_W      = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int RECIP_W    = 17;
  localparam int RECIP_SHIFT = 16;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [FACTOR_W-1:0] RST_FACTOR = 5'd2;
  localparam logic [DIM_W-1:0]    RST_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0]    RST_HEIGHT = 11'd480;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_PARAM = 2'd1,
    ST_SIZE      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_FACTOR = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_MODE   = 2'd3
  } reg_idx_t;

  // Configuration as seen by the datapath. wr pulses in the cycle of a write.
  typedef struct packed {
    logic [FACTOR_W-1:0] k;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic                mode;
    status_t             status;
    logic                busy;
    logic                wr;
  } cfg_t;

  // Per-pixel control decided from the position counters.
  typedef struct packed {
    status_t status;
    logic    first;
    logic    accum;
    logic    emit;
    logic    last;
  } item_t;

  // floor(65536 / (k*k)) for factor codes 1 to 31; code 0 holds 0.
  localparam logic [RECIP_W-1:0] RECIP_TABLE [32] = '{
    17'd0,     17'd65536, 17'd16384, 17'd7281,  17'd4096,  17'd2621,
    17'd1820,  17'd1337,  17'd1024,  17'd809,   17'd655,   17'd541,
    17'd455,   17'd387,   17'd334,   17'd291,   17'd256,   17'd226,
    17'd202,   17'd181,   17'd163,   17'd148,   17'd135,   17'd123,
    17'd113,   17'd104,   17'd96,    17'd89,    17'd83,    17'd77,
    17'd72,    17'd68
  };

endpackage

`default_nettype wire

// ===== rtl/bdown_ram.sv =====
// ============================================================================
// bdown_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module bdown_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bdown_cfg.sv =====
// ============================================================================
// bdown_cfg
// Register file on the APB port and a bit-serial check of the frame geometry.
// ============================================================================
`default_nettype none

module bdown_cfg #(
  parameter int MAX_WIDTH  = bdown_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bdown_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bdown_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [bdown_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [bdown_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output bdown_pkg::cfg_t                      cfg_o
);

  localparam int FW = bdown_pkg::FACTOR_W;
  localparam int DW = bdown_pkg::DIM_W;

  logic [FW-1:0]      k_r;
  logic [DW-1:0]      width_r;
  logic [DW-1:0]      height_r;
  logic               mode_r;
  bdown_pkg::status_t status_r, status_nxt;
  logic               busy_r, busy_nxt;
  logic [3:0]         step_r, step_nxt;
  logic [FW-1:0]      remw_r, remw_nxt;
  logic [FW-1:0]      remh_r, remh_nxt;
  logic               wr_en;
  logic [3:0]         bit_idx;
  bdown_pkg::reg_idx_t reg_idx;

  // One restoring step of the remainder by k.
  function automatic logic [FW-1:0] mod_step(input logic [FW-1:0] rem, input logic b,
                                             input logic [FW-1:0] k);
    logic [FW:0] t;
    begin
      t = {rem, b};
      if (t >= {1'b0, k}) begin
        t = t - {1'b0, k};
      end
      return t[FW-1:0];
    end
  endfunction

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = bdown_pkg::reg_idx_t'(paddr[3:2]);
  assign bit_idx = 4'(DW - 1) - step_r;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      bdown_pkg::REG_FACTOR: prdata = 32'(k_r);
      bdown_pkg::REG_WIDTH:  prdata = 32'(width_r);
      bdown_pkg::REG_HEIGHT: prdata = 32'(height_r);
      bdown_pkg::REG_MODE:   prdata = 32'(mode_r);
    endcase
  end

  always_comb begin
    busy_nxt   = busy_r;
    step_nxt   = step_r;
    status_nxt = status_r;
    remw_nxt   = mod_step(remw_r, width_r[bit_idx], k_r);
    remh_nxt   = mod_step(remh_r, height_r[bit_idx], k_r);
    if (wr_en) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      remw_nxt = '0;
      remh_nxt = '0;
    end else if (busy_r) begin
      step_nxt = step_r + 4'd1;
      if (step_r == 4'(DW - 1)) begin
        busy_nxt = 1'b0;
        if (k_r == '0 || 32'(k_r) > 32'(bdown_pkg::MAX_FACTOR)) begin
          status_nxt = bdown_pkg::ST_BAD_PARAM;
        end else if (remw_nxt != '0 || remh_nxt != '0) begin
          status_nxt = bdown_pkg::ST_SIZE;
        end else if (width_r == '0 || height_r == '0 ||
                     32'(width_r) > 32'(MAX_WIDTH) || 32'(height_r) > 32'(MAX_HEIGHT)) begin
          status_nxt = bdown_pkg::ST_BAD_PARAM;
        end else begin
          status_nxt = bdown_pkg::ST_OK;
        end
      end
    end else begin
      remw_nxt = remw_r;
      remh_nxt = remh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r      <= bdown_pkg::RST_FACTOR;
      width_r  <= bdown_pkg::RST_WIDTH;
      height_r <= bdown_pkg::RST_HEIGHT;
      mode_r   <= 1'b0;
      status_r <= bdown_pkg::ST_BAD_PARAM;
      busy_r   <= 1'b1;
      step_r   <= '0;
      remw_r   <= '0;
      remh_r   <= '0;
    end else begin
      status_r <= status_nxt;
      busy_r   <= busy_nxt;
      step_r   <= step_nxt;
      remw_r   <= remw_nxt;
      remh_r   <= remh_nxt;
      if (wr_en) begin
        unique case (reg_idx)
          bdown_pkg::REG_FACTOR: k_r      <= pwdata[FW-1:0];
          bdown_pkg::REG_WIDTH:  width_r  <= pwdata[DW-1:0];
          bdown_pkg::REG_HEIGHT: height_r <= pwdata[DW-1:0];
          bdown_pkg::REG_MODE:   mode_r   <= pwdata[0];
        endcase
      end
    end
  end

  assign cfg_o = '{k: k_r, width: width_r, height: height_r, mode: mode_r,
                   status: status_r, busy: busy_r, wr: wr_en};

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r <= 4'(DW - 1))
    else $error("geometry check ran past its last bit");

endmodule

`default_nettype wire

// ===== rtl/bdown_pos.sv =====
// ============================================================================
// bdown_pos
// Raster position counters and the per-pixel control they imply.
// ============================================================================
`default_nettype none

module bdown_pos #(
  parameter int MAX_WIDTH  = bdown_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bdown_pkg::MAX_HEIGHT_DEF,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bdown_pkg::cfg_t cfg,
  input  wire logic            accept,
  output bdown_pkg::item_t     item_o,
  output logic [CW-1:0]        idx_o
);

  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int BW  = bdown_pkg::BLK_W;
  localparam int FW  = bdown_pkg::FACTOR_W;
  localparam int DW  = bdown_pkg::DIM_W;
  localparam int PW0 = (CW > RW) ? CW : RW;
  localparam int PW  = ((PW0 > DW) ? PW0 : DW) + 1;

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] bcol_r, bcol_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [BW-1:0] cib_r, cib_nxt;
  logic [BW-1:0] rib_r, rib_nxt;

  logic [PW-1:0] col_x, row_x, w_x, h_x, k_x;
  logic [FW-1:0] k_m1;
  logic          ok, col_end, row_end, cib_end, rib_end, first, blk_end;
  logic          last_avg, last_nn;

  always_comb begin
    col_x    = PW'(col_r);
    row_x    = PW'(row_r);
    w_x      = PW'(cfg.width);
    h_x      = PW'(cfg.height);
    k_x      = PW'(cfg.k);
    k_m1     = cfg.k - FW'(1);
    ok       = (cfg.status == bdown_pkg::ST_OK);
    col_end  = col_x >= w_x - PW'(1);
    row_end  = row_x >= h_x - PW'(1);
    cib_end  = FW'(cib_r) >= k_m1;
    rib_end  = FW'(rib_r) >= k_m1;
    first    = (cib_r == '0) && (rib_r == '0);
    blk_end  = (FW'(cib_r) == k_m1) && (FW'(rib_r) == k_m1);
    last_avg = (col_x == w_x - PW'(1)) && (row_x == h_x - PW'(1));
    last_nn  = (col_x == w_x - k_x) && (row_x == h_x - k_x);

    item_o.status = cfg.status;
    item_o.first  = first;
    item_o.accum  = ok && !cfg.mode;
    item_o.emit   = !ok || (cfg.mode ? first : blk_end);
    item_o.last   = ok && (cfg.mode ? last_nn : last_avg);
  end

  assign idx_o = bcol_r;

  always_comb begin
    col_nxt  = col_r;
    bcol_nxt = bcol_r;
    row_nxt  = row_r;
    cib_nxt  = cib_r;
    rib_nxt  = rib_r;
    if (cfg.wr) begin
      col_nxt  = '0;
      bcol_nxt = '0;
      row_nxt  = '0;
      cib_nxt  = '0;
      rib_nxt  = '0;
    end else if (accept && ok) begin
      if (col_end) begin
        col_nxt  = '0;
        bcol_nxt = '0;
        cib_nxt  = '0;
        if (row_end) begin
          row_nxt = '0;
          rib_nxt = '0;
        end else begin
          row_nxt = row_r + RW'(1);
          rib_nxt = rib_end ? '0 : rib_r + BW'(1);
        end
      end else begin
        col_nxt = col_r + CW'(1);
        if (cib_end) begin
          cib_nxt  = '0;
          bcol_nxt = bcol_r + CW'(1);
        end else begin
          cib_nxt = cib_r + BW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      bcol_r <= '0;
      row_r  <= '0;
      cib_r  <= '0;
      rib_r  <= '0;
    end else begin
      col_r  <= col_nxt;
      bcol_r <= bcol_nxt;
      row_r  <= row_nxt;
      cib_r  <= cib_nxt;
      rib_r  <= rib_nxt;
    end
  end

  a_blk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!cfg.busy && cfg.status == bdown_pkg::ST_OK) |-> (FW'(cib_r) < cfg.k && FW'(rib_r) < cfg.k))
    else $error("block position outside the block");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!cfg.busy && cfg.status == bdown_pkg::ST_OK) |-> (PW'(col_r) < PW'(cfg.width)))
    else $error("column counter outside the frame");

endmodule

`default_nettype wire

// ===== rtl/bdown_acc.sv =====
// ============================================================================
// bdown_acc
// Column-sum update, reciprocal scaling and the result register.
// ============================================================================
`default_nettype none

module bdown_acc #(
  parameter int MAX_WIDTH = bdown_pkg::MAX_WIDTH_DEF,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bdown_pkg::cfg_t               cfg,
  input  wire logic                          accept,
  input  wire bdown_pkg::item_t              item,
  input  wire logic [bdown_pkg::PIX_W-1:0]   pixel,
  input  wire logic [CW-1:0]                 idx,
  input  wire logic [bdown_pkg::SUM_W-1:0]   rdata,
  output logic                               ram_we,
  output logic      [CW-1:0]                 ram_waddr,
  output logic      [bdown_pkg::SUM_W-1:0]   ram_wdata,
  output logic                               hold,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [bdown_pkg::PIX_W-1:0]   out_pixel_out,
  output logic      [1:0]                    out_status,
  output logic                               out_last_of_frame
);

  localparam int SW = bdown_pkg::SUM_W;
  localparam int XW = bdown_pkg::PIX_W;
  localparam int RW = bdown_pkg::RECIP_W;

  logic             s1_valid_r;
  bdown_pkg::item_t s1_item_r;
  logic [XW-1:0]    s1_pix_r;
  logic [CW-1:0]    s1_idx_r;

  logic             fwd_valid_r;
  logic [CW-1:0]    fwd_idx_r;
  logic [SW-1:0]    fwd_sum_r;

  logic               out_valid_r, out_valid_nxt;
  logic [XW-1:0]      out_pix_r, out_pix_nxt;
  bdown_pkg::status_t out_status_r;
  logic               out_last_r;

  logic               s1_adv;
  logic [SW-1:0]      prev_sum, sum;
  logic [RW-1:0]      recip;
  logic [SW+RW-1:0]   prod;

  assign s1_adv = s1_valid_r && (!s1_item_r.emit || !out_valid_r || !out_stall);
  assign hold   = s1_valid_r && !s1_adv;

  always_comb begin
    // The RAM read was issued as the write of the previous pixel landed:
    // take the fresher value from the forwarding register.
    prev_sum = (fwd_valid_r && fwd_idx_r == s1_idx_r) ? fwd_sum_r : rdata;
    sum      = s1_item_r.first ? SW'(s1_pix_r) : prev_sum + SW'(s1_pix_r);
    recip    = bdown_pkg::RECIP_TABLE[cfg.k];
    prod     = (SW+RW)'(sum) * (SW+RW)'(recip);

    if (s1_item_r.status != bdown_pkg::ST_OK) begin
      out_pix_nxt = '0;
    end else if (s1_item_r.accum) begin
      out_pix_nxt = prod[bdown_pkg::RECIP_SHIFT +: XW];
    end else begin
      out_pix_nxt = s1_pix_r;
    end
    out_valid_nxt = (s1_adv && s1_item_r.emit) || (out_valid_r && out_stall);
  end

  assign ram_we    = s1_adv && s1_item_r.accum;
  assign ram_waddr = s1_idx_r;
  assign ram_wdata = sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept || hold;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= item;
      s1_pix_r  <= pixel;
      s1_idx_r  <= idx;
    end
    if (ram_we) begin
      fwd_idx_r <= s1_idx_r;
      fwd_sum_r <= sum;
    end
    if (s1_adv && s1_item_r.emit) begin
      out_pix_r    <= out_pix_nxt;
      out_status_r <= s1_item_r.status;
      out_last_r   <= s1_item_r.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_out     = out_pix_r;
  assign out_status        = out_status_r;
  assign out_last_of_frame = out_last_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != bdown_pkg::ST_OK) |-> (out_pix_r == '0 && !out_last_r))
    else $error("error beat carries pixel data");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    hold |=> (s1_valid_r && $stable(s1_idx_r) && $stable(s1_pix_r)))
    else $error("held pixel changed in the sum stage");

endmodule

`default_nettype wire

// ===== rtl/block_average_downscaler.sv =====
// ============================================================================
// block_average_downscaler
// Integer box-filter / nearest-neighbour downscaler for 8-bit grey frames.
// ============================================================================
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  in_pixel_in
//   out      source     out_valid/out_stall  out_pixel_out, out_status,
//                                            out_last_of_frame
//   cfg      APB slave  psel/penable/pready  paddr, pwdata, prdata
//
// One pixel beat is taken every clock while in_stall is low. The pixel that
// causes a result is registered with its column-sum RAM read; the sum, the
// reciprocal multiply and the result register follow.
// After reset, and after every register write, in_stall stays high while a
// bit-serial unit checks that width and height divide by k.
// Reset is synchronous and active low; it restores the register defaults and
// rewinds the raster position. The column-sum RAM is not cleared.
// A stalled result holds the sum stage, and a held sum stage stalls input.
// ============================================================================
`default_nettype none

module block_average_downscaler #(
  parameter int MAX_WIDTH  = bdown_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bdown_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // pixel beats in raster order
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [bdown_pkg::PIX_W-1:0]      in_pixel_in,
  // downscaled pixel or error beats
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [bdown_pkg::PIX_W-1:0]      out_pixel_out,
  output logic      [1:0]                       out_status,
  output logic                                  out_last_of_frame,
  // configuration
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bdown_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [bdown_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [bdown_pkg::APB_DATA_W-1:0] prdata,
  output logic                                  pready
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  bdown_pkg::cfg_t  cfg;
  bdown_pkg::item_t item;
  logic [CW-1:0]    idx;
  logic             accept;
  logic             hold;
  logic             ram_we;
  logic [CW-1:0]    ram_waddr;
  logic [bdown_pkg::SUM_W-1:0] ram_wdata;
  logic [bdown_pkg::SUM_W-1:0] ram_rdata;

  // Input is refused while the geometry check runs or the sum stage is held.
  assign in_stall = cfg.busy || hold;
  assign accept   = in_valid && !in_stall;

  bdown_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Raster counters decide, per beat, whether a block starts or completes and
  // which output column's running sum the pixel belongs to.
  bdown_pos #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_pos (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .accept(accept),
    .item_o(item),
    .idx_o (idx)
  );

  // One running sum per output column; read as the pixel is taken, written
  // back from the sum stage when that stage advances.
  bdown_ram #(
    .WIDTH(bdown_pkg::SUM_W),
    .DEPTH(MAX_WIDTH)
  ) u_sums (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  bdown_acc #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_acc (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .accept           (accept),
    .item             (item),
    .pixel            (in_pixel_in),
    .idx              (idx),
    .rdata            (ram_rdata),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .hold             (hold),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_out    (out_pixel_out),
    .out_status       (out_status),
    .out_last_of_frame(out_last_of_frame)
  );

endmodule

`default_nettype wire
